>>> rtl/dcwf_pkg.sv
// Package with shared types and constants of the digit control word former.
package dcwf_pkg;

    typedef enum logic [1:0] {
        OP_DEC  = 2'd0,
        OP_HEX  = 2'd1,
        OP_SYN  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_DMF_DEVICE    = 2'd0,
        CFG_SYNTH_DEVICE  = 2'd1,
        CFG_SYNTH_HEX_TOP = 2'd2,
        CFG_UNUSED        = 2'd3
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [30:0] value;
        logic [4:0]  digit_count;
        logic [4:0]  first_digit;
        logic [6:0]  device_address;
    } t_item;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
    } t_result;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } t_cmd;

    localparam logic [15:0] WORD_FLAG   = 16'h8000;
    localparam logic [5:0]  REMAP_FROM  = 6'd16;
    localparam logic [5:0]  REMAP_TO    = 6'd11;
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          RESULT_LIMIT = 16;

endpackage

>>> rtl/dcwf_ctrl.sv
// Controller state machine that sequences the digit words of one request.
module dcwf_ctrl
    import dcwf_pkg::*;
#(
    parameter int MAX_DIGITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_operation,
    input  logic [4:0] i_digit_count,
    output logic       o_busy,
    output t_cmd       o_cmd
);

    localparam int LIMIT = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;

    t_state     r_state, n_state;
    logic [4:0] r_left, n_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
        end
    end

    always_comb begin
        n_state = r_state;
        n_left  = r_left;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && (t_op'(i_operation) != OP_NONE) && (i_digit_count != '0)) begin
                    o_cmd.load = 1'b1;
                    n_left     = (i_digit_count > 5'(LIMIT)) ? 5'(LIMIT) : i_digit_count;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.step = 1'b1;
                o_cmd.last = (r_left == 5'd1);
                n_left     = r_left - 5'd1;
                if (r_left == 5'd1) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state == ST_RUN);

    a_run_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_left != '0))
        else $error("controller runs with no digits left");

    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left <= 5'(LIMIT)))
        else $error("digit counter exceeds its limit");

    a_load_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (o_busy && !o_cmd.load))
        else $error("load did not enter the run state");

endmodule

>>> rtl/dcwf_datapath.sv
// Datapath: configuration registers, digit extraction and bus word forming.
module dcwf_datapath
    import dcwf_pkg::*;
#(
    parameter int DEVICE_SHIFT = 8,
    parameter int DIGIT_SHIFT  = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  t_item      i_item,
    input  t_cmd       i_cmd,
    output logic       o_valid,
    output t_result    o_result
);

    logic [6:0]  r_dmf_device;
    logic [6:0]  r_synth_device;
    logic        r_synth_hex_top;

    logic [30:0] r_v;
    t_op         r_op;
    logic [5:0]  r_idx;
    logic [6:0]  r_dev;
    logic        r_valid;
    t_result     r_result;

    logic [62:0] prod;
    logic [27:0] q10;
    logic [30:0] rem_full;
    logic        use_hex;
    logic [3:0]  dig;
    logic [30:0] n_v;
    logic [5:0]  idx;
    logic [6:0]  dev;
    logic [31:0] word_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmf_device    <= '0;
            r_synth_device  <= '0;
            r_synth_hex_top <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DMF_DEVICE:    r_dmf_device    <= i_cfg_data;
                CFG_SYNTH_DEVICE:  r_synth_device  <= i_cfg_data;
                CFG_SYNTH_HEX_TOP: r_synth_hex_top <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Division by ten uses a reciprocal multiply, exact for any 31-bit value.
    always_comb begin
        prod     = 63'(r_v) * 63'(RECIP_TEN);
        q10      = prod[62:RECIP_SHIFT];
        rem_full = r_v - {q10, 3'b000} - 31'({q10, 1'b0});
        use_hex  = (r_op == OP_HEX) || ((r_op == OP_SYN) && r_synth_hex_top && i_cmd.last);
        if (use_hex) begin
            n_v = {4'b0000, r_v[30:4]};
            dig = (r_op == OP_HEX) ? ~r_v[3:0] : r_v[3:0];
        end else begin
            n_v = {3'b000, q10};
            dig = rem_full[3:0];
        end
        idx = r_idx;
        dev = r_dev;
        if (r_op == OP_SYN) begin
            dev = r_synth_device;
        end
        if ((r_op == OP_DEC) && (r_idx == REMAP_FROM) && (r_dev == r_dmf_device)) begin
            idx = REMAP_TO;
        end
        word_full = 32'(WORD_FLAG) | (32'(dev) << DEVICE_SHIFT)
                  | (32'(idx) << DIGIT_SHIFT) | 32'(dig);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v   <= i_item.value;
            r_op  <= t_op'(i_item.operation);
            r_idx <= {1'b0, i_item.first_digit};
            r_dev <= i_item.device_address;
        end else if (i_cmd.step) begin
            r_v   <= n_v;
            r_idx <= r_idx + 6'd1;
        end
        if (i_cmd.step) begin
            r_result.word <= word_full[15:0];
            r_result.last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.step;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_result.last) |=> !r_valid)
        else $error("result strobe directly after the final word");

    a_flag_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_result.word[15])
        else $error("bus word lacks its flag bit");

    a_no_load_while_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load && i_cmd.step))
        else $error("load and step issued together");

endmodule

>>> rtl/digit_control_word_former.sv
// Top level of the digit control word former: controller, datapath and ports.
//
//  Channel   Signals                                   Accepted when
//  --------  ----------------------------------------  ---------------------------
//  request   start, busy, i_item                       start high and busy low
//  result    o_result_valid, o_result                  every cycle the strobe is high
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index,    i_cfg_valid high (ready is
//            i_cfg_data                                always high)
//
// A request with digit count N (saturated to the digit limit, at most 16) gives
// N digit words: it is first loaded, then the digit loop forms one digit word per cycle,
// each digit costing one reciprocal multiply by ten or a nibble shift.
// Each word is registered before it shows on the result ports,
// and a new request is taken again in the cycle that shows the final word.
// Operation code 3 and a digit count of zero are accepted and give no words.
// Reset is synchronous and active low; it clears the configuration registers
// and the controller. The receiver cannot stall: each word is shown for one cycle.
module digit_control_word_former
    import dcwf_pkg::*;
#(
    parameter int DEVICE_SHIFT = 8,
    parameter int DIGIT_SHIFT  = 4,
    parameter int MAX_DIGITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_item      i_item,
    output logic       o_result_valid,
    output t_result    o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    t_cmd cmd;

    // Configuration is always taken at once.
    assign o_cfg_ready = 1'b1;

    dcwf_ctrl #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_operation  (i_item.operation),
        .i_digit_count(i_item.digit_count),
        .o_busy       (busy),
        .o_cmd        (cmd)
    );

    dcwf_datapath #(
        .DEVICE_SHIFT(DEVICE_SHIFT),
        .DIGIT_SHIFT (DIGIT_SHIFT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (cmd),
        .o_valid    (o_result_valid),
        .o_result   (o_result)
    );

endmodule

>>> sim/tb.sv
// Self-checking testbench of the digit control word former.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dcwf_pkg::*;

    // Geometry of the block under test, passed to the instance and used by the
    // word predictor so that both agree on where each part of a word lands.
    localparam int DEV_SHIFT   = 8;
    localparam int DIG_SHIFT   = 4;
    localparam int DIGIT_LIMIT = 16;

    localparam int RAND_PHASES    = 6;
    localparam int RAND_PER_PHASE = 44;
    // Wait after the last expected word, long enough that any request still
    // in flight that has no word left to show can finish.
    localparam int SETTLE_CYCLES  = 24;
    localparam int CYCLE_LIMIT    = 200000;

    // One row of the directed table. Rows with typed set carry their expected
    // outcome by hand: nwords is 0 (silent request) or 1 (single word, last set).
    // All other rows are checked against the word predictor.
    typedef struct packed {
        t_item       item;
        logic        typed;
        logic [4:0]  nwords;
        logic [15:0] word;
    } t_row;

    localparam int N_ROWS = 21;
    localparam t_row ROWS [N_ROWS] = '{
        // Single words read straight off the word layout, reset configuration.
        '{'{OP_DEC,  31'd0,          5'd1,  5'd0,  7'd0},   1'b1, 5'd1, 16'h8000},
        // Index 16 on the DMF device (address 0 after reset) becomes index 11.
        '{'{OP_DEC,  31'd7,          5'd1,  5'd16, 7'd0},   1'b1, 5'd1, 16'h80B7},
        // Top value, top index and top device all overlap in the upper bits.
        '{'{OP_DEC,  31'h7FFF_FFFF,  5'd1,  5'd31, 7'd127}, 1'b1, 5'd1, 16'hFFF7},
        '{'{OP_HEX,  31'd0,          5'd1,  5'd0,  7'd0},   1'b1, 5'd1, 16'h800F},
        '{'{OP_HEX,  31'h7FFF_FFFF,  5'd1,  5'd5,  7'h55},  1'b1, 5'd1, 16'hD550},
        // The synthesizer ignores the request's device and uses its register.
        '{'{OP_SYN,  31'd9,          5'd1,  5'd3,  7'd99},  1'b1, 5'd1, 16'h8039},
        // Requests that produce no words at all.
        '{'{OP_NONE, 31'd123,        5'd5,  5'd0,  7'd0},   1'b1, 5'd0, 16'h0000},
        '{'{OP_DEC,  31'd55,         5'd0,  5'd0,  7'd0},   1'b1, 5'd0, 16'h0000},
        '{'{OP_HEX,  31'd55,         5'd0,  5'd0,  7'd0},   1'b1, 5'd0, 16'h0000},
        '{'{OP_SYN,  31'd55,         5'd0,  5'd0,  7'd0},   1'b1, 5'd0, 16'h0000},
        '{'{OP_NONE, 31'h7FFF_FFFF,  5'd31, 5'd31, 7'd127}, 1'b1, 5'd0, 16'h0000},
        // Multi-word rows, checked by the predictor.
        '{'{OP_DEC,  31'h7FFF_FFFF,  5'd16, 5'd0,  7'd1},   1'b0, 5'd0, 16'h0000},
        '{'{OP_DEC,  31'd123456789,  5'd31, 5'd10, 7'd0},   1'b0, 5'd0, 16'h0000},
        '{'{OP_DEC,  31'd2468,       5'd16, 5'd31, 7'd127}, 1'b0, 5'd0, 16'h0000},
        '{'{OP_HEX,  31'h5A5A_5A5A,  5'd16, 5'd0,  7'd42},  1'b0, 5'd0, 16'h0000},
        '{'{OP_HEX,  31'h1234_5678,  5'd31, 5'd20, 7'd0},   1'b0, 5'd0, 16'h0000},
        '{'{OP_SYN,  31'h7FFF_FFFF,  5'd10, 5'd0,  7'd5},   1'b0, 5'd0, 16'h0000},
        '{'{OP_DEC,  31'd987654321,  5'd16, 5'd16, 7'd3},   1'b0, 5'd0, 16'h0000},
        '{'{OP_SYN,  31'd4321,       5'd16, 5'd16, 7'd0},   1'b0, 5'd0, 16'h0000},
        '{'{OP_HEX,  31'd7,          5'd16, 5'd16, 7'd0},   1'b0, 5'd0, 16'h0000},
        '{'{OP_DEC,  31'd0,          5'd16, 5'd0,  7'd0},   1'b0, 5'd0, 16'h0000}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_item      i_item;
    logic       o_result_valid;
    t_result    o_result;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [6:0] i_cfg_data;

    // Side information that travels with the request currently on i_item.
    logic        req_typed;
    logic [4:0]  req_nwords;
    logic [15:0] req_word;

    // Shadow copy of the configuration registers, kept up to date by the monitor.
    logic [6:0] dmf_dev   = '0;
    logic [6:0] synth_dev = '0;
    logic       hex_top   = 1'b0;

    t_result pending_words [$];
    int      mismatches = 0;
    int      requests   = 0;
    int      words_seen = 0;
    int      settings   = 1;
    int      cycles     = 0;
    bit      calm       = 1'b0;

    digit_control_word_former #(
        .DEVICE_SHIFT (DEV_SHIFT),
        .DIGIT_SHIFT  (DIG_SHIFT),
        .MAX_DIGITS   (DIGIT_LIMIT)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Works out every bus word that one accepted request must produce and
    // queues them in order. Digits come out least significant first; the
    // digit index is left unmasked so that large indexes spill into the
    // device bits before the word is cut to sixteen bits.
    function automatic void form_words(t_item it);
        int unsigned v;
        int unsigned n;
        int unsigned idx;
        int unsigned dig;
        int unsigned dev;
        int unsigned full;
        t_result     r;
        if (it.operation == OP_NONE)
            return;
        v = it.value;
        n = it.digit_count;
        if (n > DIGIT_LIMIT)
            n = DIGIT_LIMIT;
        if (n > RESULT_LIMIT)
            n = RESULT_LIMIT;
        for (int unsigned k = 0; k < n; k++) begin
            idx = it.first_digit + k;
            dev = it.device_address;
            if (it.operation == OP_DEC) begin
                dig = v % 10;
                v   = v / 10;
                // Only the decimal operation remaps index 16 on the DMF device.
                if (idx == REMAP_FROM && dev == dmf_dev)
                    idx = REMAP_TO;
            end else if (it.operation == OP_HEX) begin
                dig = ~(v % 16) & 4'hF;
                v   = v / 16;
            end else begin
                dev = synth_dev;
                if (hex_top && k + 1 == n) begin
                    dig = v % 16;
                    v   = v / 16;
                end else begin
                    dig = v % 10;
                    v   = v / 10;
                end
            end
            full   = WORD_FLAG | ((dev & 7'h7F) << DEV_SHIFT) | (idx << DIG_SHIFT)
                   | (dig & 4'hF);
            r.word = full[15:0];
            r.last = (k + 1 == n);
            pending_words.push_back(r);
        end
    endfunction

    function automatic void report_mismatch(string what, t_result want, t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s: expected word %h last %b, got word %h last %b",
                     $time, what, want.word, want.last, got.word, got.last);
    endfunction

    // Monitor: checks every shown word against the oldest expectation, queues
    // the words of every accepted request and mirrors register writes. All of
    // it samples at the rising edge, while the testbench drives at the falling one.
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                got = o_result;
                words_seen++;
                if (pending_words.size() == 0) begin
                    report_mismatch("word with none pending", '0, got);
                end else begin
                    want = pending_words.pop_front();
                    if (got.word !== want.word)
                        report_mismatch("word field", want, got);
                    else if (got.last !== want.last)
                        report_mismatch("last flag", want, got);
                end
            end
            if (start && !busy) begin
                if (req_typed) begin
                    if (req_nwords != 0)
                        pending_words.push_back('{word: req_word, last: 1'b1});
                end else begin
                    form_words(i_item);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DMF_DEVICE:    dmf_dev   = i_cfg_data;
                    CFG_SYNTH_DEVICE:  synth_dev = i_cfg_data;
                    CFG_SYNTH_HEX_TOP: hex_top   = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: a lost word or a stuck busy ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words pending.",
                     cycles, pending_words.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Idle time before a request: usually none or a few cycles, now and then a
    // long pause, and in calm stretches none at all.
    function automatic int idle_gap();
        int unsigned pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Random request: mostly the three live operations with counts inside the
    // digit limit, some oversized or zero counts, and a share of decimal
    // requests aimed at the DMF remap.
    function automatic t_item random_request();
        t_item       it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            it.operation = OP_DEC;
        else if (pick < 65)
            it.operation = OP_HEX;
        else if (pick < 94)
            it.operation = OP_SYN;
        else
            it.operation = OP_NONE;
        if ($urandom_range(0, 1) == 1)
            it.value = 31'($urandom);
        else
            it.value = 31'($urandom_range(0, 99999));
        pick = $urandom_range(0, 99);
        if (pick < 80)
            it.digit_count = 5'($urandom_range(1, 16));
        else if (pick < 94)
            it.digit_count = 5'($urandom_range(17, 31));
        else
            it.digit_count = 5'd0;
        it.first_digit    = 5'($urandom_range(0, 31));
        it.device_address = 7'($urandom);
        if (it.operation == OP_DEC && $urandom_range(0, 2) == 0) begin
            it.device_address = dmf_dev;
            it.first_digit    = 5'($urandom_range(0, 16));
        end
        return it;
    endfunction

    // Presents one request after an idle gap and holds it until it is taken.
    task automatic issue(t_item it, logic typed, logic [4:0] nwords, logic [15:0] word);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk) start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_item     <= it;
        req_typed  <= typed;
        req_nwords <= nwords;
        req_word   <= word;
        do @(posedge i_clk); while (busy);
        requests++;
    endtask

    task automatic write_reg(t_cfg_index idx, logic [6:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    // Waits until every expected word has been shown, then lets a silent
    // request that may still be in flight finish as well.
    task automatic settle();
        do @(negedge i_clk); while (pending_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [6:0] d_dmf;
        logic [6:0] d_syn;
        logic [6:0] d_top;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DMF_DEVICE;
        i_cfg_data  = '0;
        req_typed   = 1'b0;
        req_nwords  = '0;
        req_word    = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed table, run on the reset configuration.
        for (int r = 0; r < N_ROWS; r++) begin
            if (r % 8 == 0)
                calm = ($urandom_range(0, 3) == 0);
            issue(ROWS[r].item, ROWS[r].typed, ROWS[r].nwords, ROWS[r].word);
        end
        @(negedge i_clk) start <= 1'b0;
        settle();

        // Random phases, each under its own register setting. The first three
        // settings hold the extremes; the hex-top register also gets junk in
        // its upper data bits, which must be ignored.
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin
                    d_dmf = 7'd127;
                    d_syn = 7'd127;
                    d_top = 7'd1;
                end
                1: begin
                    d_dmf = 7'd0;
                    d_syn = 7'd127;
                    d_top = 7'd0;
                end
                2: begin
                    d_dmf = 7'd127;
                    d_syn = 7'd0;
                    d_top = 7'h7E;
                end
                default: begin
                    d_dmf = 7'($urandom);
                    d_syn = 7'($urandom);
                    d_top = 7'($urandom);
                end
            endcase
            write_reg(CFG_DMF_DEVICE, d_dmf);
            write_reg(CFG_SYNTH_DEVICE, d_syn);
            write_reg(CFG_SYNTH_HEX_TOP, d_top);
            // The spare index must not disturb any register.
            if (p == 2)
                write_reg(CFG_UNUSED, 7'($urandom));
            settings++;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (n % 16 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                issue(random_request(), 1'b0, 5'd0, 16'h0000);
            end
            @(negedge i_clk) start <= 1'b0;
            settle();
        end

        $display("Run covered %0d requests (%0d from the directed table) and %0d bus words",
                 requests, N_ROWS, words_seen);
        $display("under %0d register settings; %0d mismatches seen.", settings, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
